@@ hw/rtl/mdb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdb_pkg
// Shared types and constants for the Morse digit beacon: register indexes,
// reset values, hold and symbol codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package mdb_pkg;

  localparam int unsigned TICK_W = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_DOT      = 3'd0;
  localparam logic [2:0] REG_DASH     = 3'd1;
  localparam logic [2:0] REG_EGAP     = 3'd2;
  localparam logic [2:0] REG_DGAP     = 3'd3;
  localparam logic [2:0] REG_SEQ_GAP  = 3'd4;
  localparam logic [2:0] REG_CODE     = 3'd5;

  // Register reset values.
  localparam logic [TICK_W-1:0] RST_DOT     = 16'd1000;
  localparam logic [TICK_W-1:0] RST_DASH    = 16'd3000;
  localparam logic [TICK_W-1:0] RST_EGAP    = 16'd1000;
  localparam logic [TICK_W-1:0] RST_DGAP    = 16'd3000;
  localparam logic [TICK_W-1:0] RST_SEQ_GAP = 16'd7000;
  localparam logic [TICK_W-1:0] RST_CODE    = 16'h1000;

  // Hold kinds. Codes above HOLD_DGAP behave as a zero-length hold.
  localparam logic [2:0] HOLD_ZERO = 3'd0;
  localparam logic [2:0] HOLD_DOT  = 3'd1;
  localparam logic [2:0] HOLD_DASH = 3'd2;
  localparam logic [2:0] HOLD_EGAP = 3'd3;
  localparam logic [2:0] HOLD_DGAP = 3'd4;

  // Symbol under the sequence pointer.
  localparam logic [1:0] SYM_END  = 2'd0;
  localparam logic [1:0] SYM_DOT  = 2'd1;
  localparam logic [1:0] SYM_DASH = 2'd2;
  localparam logic [1:0] SYM_SEP  = 2'd3;

  // Elements sent for one valid decimal digit.
  localparam logic [3:0] DIGIT_ELEMS = 4'd5;
  localparam logic [3:0] MAX_DIGIT   = 4'd9;

  typedef struct packed {
    logic [TICK_W-1:0] dot_ticks;
    logic [TICK_W-1:0] dash_ticks;
    logic [TICK_W-1:0] element_gap_ticks;
    logic [TICK_W-1:0] digit_gap_ticks;
    logic [TICK_W-1:0] sequence_gap_ticks;
    logic [TICK_W-1:0] code_digits;
  } cfg_t;

  typedef struct packed {
    logic              lamp_on;
    logic              in_pause;
    logic [2:0]        digit_pos;
    logic [2:0]        symbol_pos;
    logic [2:0]        hold_kind;
    logic [TICK_W-1:0] elapsed;
  } state_t;

  typedef struct packed {
    logic lamp;
    logic pausing;
  } result_t;

endpackage : mdb_pkg
`default_nettype wire

@@ hw/rtl/mdb_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdb_step
// Next-state logic for one tick: picks the symbol under the pointer, checks
// the running hold and advances the Morse sequence, pause and elapsed count.
// ----------------------------------------------------------------------------
module mdb_step #(
  parameter int unsigned DIGITS = 4
) (
  input  wire mdb_pkg::cfg_t    cfg,
  input  wire mdb_pkg::state_t  cur,
  input  wire                   enable,
  output mdb_pkg::state_t       nxt,
  output mdb_pkg::result_t      res
);
  import mdb_pkg::*;

  localparam logic [2:0] LAST_POS   = 3'(DIGITS - 1);
  localparam logic [3:0] DIGITS_W   = 4'(DIGITS);

  logic [2:0]        nib_idx;
  logic [3:0]        nib;
  logic [3:0]        sym_pos_w;
  logic [1:0]        sym;
  logic [TICK_W-1:0] hold_len;
  logic [TICK_W-1:0] elapsed_inc;

  // Pick the nibble of the current digit; positions past the register read as 0.
  always_comb begin
    nib_idx = LAST_POS - cur.digit_pos;
    nib     = 4'd0;
    if (!nib_idx[2]) begin
      case (nib_idx[1:0])
        2'd0:    nib = cfg.code_digits[3:0];
        2'd1:    nib = cfg.code_digits[7:4];
        2'd2:    nib = cfg.code_digits[11:8];
        default: nib = cfg.code_digits[15:12];
      endcase
    end
  end

  always_comb begin
    sym_pos_w = {1'b0, cur.symbol_pos};
    if ({1'b0, cur.digit_pos} >= DIGITS_W) begin
      sym = SYM_END;
    end else if (nib <= MAX_DIGIT && sym_pos_w < DIGIT_ELEMS) begin
      if (nib <= DIGIT_ELEMS) begin
        sym = (sym_pos_w < nib) ? SYM_DOT : SYM_DASH;
      end else begin
        sym = (sym_pos_w < (nib - DIGIT_ELEMS)) ? SYM_DASH : SYM_DOT;
      end
    end else if (({1'b0, cur.digit_pos} + 4'd1) < DIGITS_W) begin
      sym = SYM_SEP;
    end else begin
      sym = SYM_END;
    end
  end

  always_comb begin
    case (cur.hold_kind)
      HOLD_DOT:  hold_len = cfg.dot_ticks;
      HOLD_DASH: hold_len = cfg.dash_ticks;
      HOLD_EGAP: hold_len = cfg.element_gap_ticks;
      HOLD_DGAP: hold_len = cfg.digit_gap_ticks;
      default:   hold_len = '0;
    endcase
  end

  assign elapsed_inc = (cur.elapsed == '1) ? cur.elapsed : cur.elapsed + 1'b1;

  always_comb begin
    nxt = cur;
    if (!enable) begin
      nxt.elapsed = elapsed_inc;
    end else if (cur.in_pause) begin
      if (cur.elapsed >= cfg.sequence_gap_ticks) begin
        nxt.in_pause   = 1'b0;
        nxt.digit_pos  = '0;
        nxt.symbol_pos = '0;
      end
      nxt.elapsed = elapsed_inc;
    end else if (sym == SYM_END) begin
      // The pass ends without waiting out the last element gap.
      nxt.in_pause = 1'b1;
      nxt.lamp_on  = 1'b0;
      nxt.elapsed  = TICK_W'(1);
    end else if (cur.elapsed >= hold_len) begin
      if (sym == SYM_SEP) begin
        nxt.lamp_on    = 1'b0;
        nxt.hold_kind  = HOLD_DGAP;
        nxt.digit_pos  = cur.digit_pos + 3'd1;
        nxt.symbol_pos = '0;
      end else begin
        nxt.lamp_on = !cur.lamp_on;
        if (!cur.lamp_on) begin
          nxt.hold_kind = (sym == SYM_DOT) ? HOLD_DOT : HOLD_DASH;
        end else begin
          nxt.hold_kind  = HOLD_EGAP;
          nxt.symbol_pos = cur.symbol_pos + 3'd1;
        end
      end
      nxt.elapsed = TICK_W'(1);
    end else begin
      nxt.elapsed = elapsed_inc;
    end
  end

  assign res.lamp    = enable & nxt.lamp_on;
  assign res.pausing = nxt.in_pause;

endmodule : mdb_step
`default_nettype wire

@@ hw/rtl/mdb_obuf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdb_obuf
// Two-entry result buffer: an output register backed by a skid register, so
// an item can be taken in the same cycle that a stalled result is waiting.
// ----------------------------------------------------------------------------
module mdb_obuf (
  input  wire               clk,
  input  wire               rst,
  input  wire               push_valid,
  output logic              push_ready,
  input  wire mdb_pkg::result_t push_data,
  output logic              pop_valid,
  input  wire               pop_ready,
  output mdb_pkg::result_t  pop_data
);
  import mdb_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    push;
  logic    head_free;

  assign push_ready = !skid_valid;
  assign push       = push_valid && push_ready;
  assign head_free  = !pop_valid || pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      pop_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      pop_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // The skid register only fills behind a stalled head.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> pop_valid)
    else $error("skid entry held while output register is empty");

  // A stalled item with a full skid must never be lost or overwritten.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !pop_ready) |=> (skid_valid && pop_valid && $stable(skid_data)))
    else $error("buffered item lost under stall");

endmodule : mdb_obuf
`default_nettype wire

@@ hw/rtl/morse_digit_beacon_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// morse_digit_beacon_core
// Spells a configured BCD code in Morse on a lamp, one tick per item.
//
//   Channel  Signals                          Direction  Payload
//   in       in_valid / in_ready              sink       enable
//   out      out_valid / out_ready            source     lamp, pausing
//   cfg      cfg_write, cfg_index, cfg_data   sink       16-bit register
//
// One tick is taken per clock cycle while in_ready is high; its result is
// registered in the output buffer. The beacon state advances through
// combinational logic, so the rate is set only by the output buffer: in_ready
// drops only when both its entries hold results. Synchronous reset restores all
// register defaults and the start of the sequence. No clearing pass is needed.
// ----------------------------------------------------------------------------
module morse_digit_beacon_core #(
  parameter int unsigned DIGITS = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         enable,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        lamp,
  output logic        pausing,
  input  wire         cfg_write,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import mdb_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t step_res;
  result_t out_res;
  logic    accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_ticks          <= RST_DOT;
      cfg.dash_ticks         <= RST_DASH;
      cfg.element_gap_ticks  <= RST_EGAP;
      cfg.digit_gap_ticks    <= RST_DGAP;
      cfg.sequence_gap_ticks <= RST_SEQ_GAP;
      cfg.code_digits        <= RST_CODE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DOT:     cfg.dot_ticks          <= cfg_data;
        REG_DASH:    cfg.dash_ticks         <= cfg_data;
        REG_EGAP:    cfg.element_gap_ticks  <= cfg_data;
        REG_DGAP:    cfg.digit_gap_ticks    <= cfg_data;
        REG_SEQ_GAP: cfg.sequence_gap_ticks <= cfg_data;
        REG_CODE:    cfg.code_digits        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.lamp_on    <= 1'b0;
      state.in_pause   <= 1'b0;
      state.digit_pos  <= '0;
      state.symbol_pos <= '0;
      state.hold_kind  <= HOLD_ZERO;
      state.elapsed    <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  mdb_step #(
    .DIGITS (DIGITS)
  ) u_step (
    .cfg    (cfg),
    .cur    (state),
    .enable (enable),
    .nxt    (state_next),
    .res    (step_res)
  );

  mdb_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (step_res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_res)
  );

  assign lamp    = out_res.lamp;
  assign pausing = out_res.pausing;

  // The lamp is always dark during the pause between passes.
  a_pause_dark: assert property (@(posedge clk) disable iff (rst)
    state.in_pause |-> !state.lamp_on)
    else $error("lamp on during pause");

  // The digit pointer never runs past the last digit.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, state.digit_pos} <= 4'(DIGITS - 1))
    else $error("digit pointer out of range");

endmodule : morse_digit_beacon_core
`default_nettype wire

@@ sim/morse_digit_beacon_core_test.sv @@
// ----------------------------------------------------------------------------
// morse_digit_beacon_core_test
// Self-checking bench for the Morse digit beacon. Ticks go in through the
// valid/ready input channel, and a behavioral beacon in the bench predicts
// the lamp and pause flags of every tick. The run steps through register
// settings (zero, short and long holds; valid, zero and invalid digits)
// and through several sender and receiver pacing modes.
// ----------------------------------------------------------------------------
module morse_digit_beacon_core_test;
  import mdb_pkg::*;

  localparam int DIGIT_COUNT = 4;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        enable = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        lamp;
  logic        pausing;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = REG_DOT;
  logic [15:0] cfg_data = '0;

  morse_digit_beacon_core #(.DIGITS(DIGIT_COUNT)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .enable    (enable),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .lamp      (lamp),
    .pausing   (pausing),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the beacon registers and sequence state.
  cfg_t        beacon_cfg = '{dot_ticks: RST_DOT, dash_ticks: RST_DASH,
                              element_gap_ticks: RST_EGAP, digit_gap_ticks: RST_DGAP,
                              sequence_gap_ticks: RST_SEQ_GAP, code_digits: RST_CODE};
  logic        lit = 1'b0;
  logic        pause_on = 1'b0;
  logic [2:0]  digit_at = '0;
  logic [2:0]  elem_at = '0;
  logic [2:0]  hold_now = HOLD_ZERO;
  logic [15:0] ticks_since = '0;

  logic        tick_queue[$];
  result_t     lamp_due[$];
  result_t     got_now;
  result_t     want_now;
  logic        in_took = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void count_tick();
    if (ticks_since != 16'hFFFF) ticks_since++;
  endfunction

  function automatic logic [15:0] hold_ticks(input logic [2:0] kind);
    case (kind)
      HOLD_DOT:  return beacon_cfg.dot_ticks;
      HOLD_DASH: return beacon_cfg.dash_ticks;
      HOLD_EGAP: return beacon_cfg.element_gap_ticks;
      HOLD_DGAP: return beacon_cfg.digit_gap_ticks;
      default:   return '0;
    endcase
  endfunction

  function automatic logic [1:0] next_symbol();
    int         shift;
    logic [3:0] nib;
    logic [3:0] pos;
    if (int'(digit_at) >= DIGIT_COUNT) return SYM_END;
    shift = 4 * (DIGIT_COUNT - 1 - int'(digit_at));
    nib = (shift < 16) ? 4'(beacon_cfg.code_digits >> shift) : 4'd0;
    pos = {1'b0, elem_at};
    if (nib <= MAX_DIGIT && pos < DIGIT_ELEMS) begin
      // Digits one to five start with dots; zero and six and above start with dashes.
      if (nib <= DIGIT_ELEMS) return (pos < nib) ? SYM_DOT : SYM_DASH;
      return (pos < nib - DIGIT_ELEMS) ? SYM_DASH : SYM_DOT;
    end
    if (int'(digit_at) + 1 < DIGIT_COUNT) return SYM_SEP;
    return SYM_END;
  endfunction

  function automatic result_t advance_beacon(input logic en);
    logic [1:0] sym;
    result_t    res;
    if (!en) begin
      count_tick();
    end else if (pause_on) begin
      if (ticks_since >= beacon_cfg.sequence_gap_ticks) begin
        pause_on = 1'b0;
        digit_at = '0;
        elem_at = '0;
      end
      count_tick();
    end else begin
      sym = next_symbol();
      if (sym == SYM_END) begin
        pause_on = 1'b1;
        lit = 1'b0;
        ticks_since = 16'd1;
      end else if (ticks_since >= hold_ticks(hold_now)) begin
        if (sym == SYM_SEP) begin
          lit = 1'b0;
          hold_now = HOLD_DGAP;
          digit_at = digit_at + 3'd1;
          elem_at = '0;
        end else begin
          lit = ~lit;
          if (lit) begin
            hold_now = (sym == SYM_DOT) ? HOLD_DOT : HOLD_DASH;
          end else begin
            hold_now = HOLD_EGAP;
            elem_at = elem_at + 3'd1;
          end
        end
        ticks_since = 16'd1;
      end else begin
        count_tick();
      end
    end
    res.lamp = en & lit;
    res.pausing = pause_on;
    return res;
  endfunction

  // Driver: presents queued ticks, holding each one until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        enable <= tick_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts on every accepted tick and checks every taken result.
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) lamp_due.push_back(advance_beacon(enable));
      if (out_valid && out_ready) begin
        got_now.lamp = lamp;
        got_now.pausing = pausing;
        if (lamp_due.size() == 0) begin
          report_mismatch("result with no tick waiting");
        end else begin
          want_now = lamp_due.pop_front();
          if (got_now.lamp !== want_now.lamp)
            report_mismatch($sformatf("lamp got %b want %b", got_now.lamp, want_now.lamp));
          if (got_now.pausing !== want_now.pausing)
            report_mismatch($sformatf("pausing got %b want %b",
                                      got_now.pausing, want_now.pausing));
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_DOT:     beacon_cfg.dot_ticks = val;
      REG_DASH:    beacon_cfg.dash_ticks = val;
      REG_EGAP:    beacon_cfg.element_gap_ticks = val;
      REG_DGAP:    beacon_cfg.digit_gap_ticks = val;
      REG_SEQ_GAP: beacon_cfg.sequence_gap_ticks = val;
      REG_CODE:    beacon_cfg.code_digits = val;
      default:     ;
    endcase
  endtask

  task automatic program_beacon(input logic [15:0] dot, input logic [15:0] dash,
                                input logic [15:0] egap, input logic [15:0] dgap,
                                input logic [15:0] seq, input logic [15:0] code);
    write_reg(REG_DOT, dot);
    write_reg(REG_DASH, dash);
    write_reg(REG_EGAP, egap);
    write_reg(REG_DGAP, dgap);
    write_reg(REG_SEQ_GAP, seq);
    write_reg(REG_CODE, code);
  endtask

  // Drops the write enable and returns on a rising edge, so new ticks are
  // queued well away from the falling edge where the driver acts.
  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Checked on rising edges, where the driver never changes the queue or
  // in_valid, so a tick popped at a falling edge cannot slip past.
  task automatic wait_drained();
    @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || lamp_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_pace(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  // Mostly running ticks, with short bursts where the beacon is disabled.
  task automatic queue_ticks(input int count);
    int held_off;
    held_off = 0;
    for (int i = 0; i < count; i++) begin
      if (held_off > 0) begin
        tick_queue.push_back(1'b0);
        held_off--;
      end else if ($urandom_range(99) < 6) begin
        tick_queue.push_back(1'b0);
        held_off = $urandom_range(1, 6);
      end else begin
        tick_queue.push_back(1'b1);
      end
    end
  endtask

  // Short holds dominate so that whole passes fit in one phase.
  function automatic logic [15:0] pick_ticks();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'd0;
    if (roll < 20) return 16'd1;
    if (roll < 70) return 16'($urandom_range(2, 4));
    if (roll < 97) return 16'($urandom_range(5, 24));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_code();
    logic [15:0] code;
    code = '0;
    for (int d = 0; d < 4; d++)
      code = {code[11:0], 4'(($urandom_range(99) < 75) ? $urandom_range(9)
                                                        : $urandom_range(10, 15))};
    return code;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: the first tick lights a dot, disabling hides it.
    tick_queue = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    wait_drained();

    // Writes to unused indexes must change nothing; then a zero-hold pass
    // with leading zero, an invalid digit, a pause and its exit.
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    program_beacon(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'h0F91);
    end_writes();
    repeat (20) tick_queue.push_back(1'b1);
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      set_pace(p % 4);
      program_beacon(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                     (p == 0) ? 16'h0000 : (p == 1) ? 16'h9999 :
                     (p == 2) ? 16'hFFFF : pick_code());
      if (p % 3 == 0) write_reg(($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                                16'($urandom));
      end_writes();
      queue_ticks(110);
      wait_drained();
    end

    // Longest holds at full pace, with disabled ticks mixed in.
    set_pace(0);
    program_beacon(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, RST_CODE);
    end_writes();
    queue_ticks(40);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mdb_pkg.sv
hw/rtl/mdb_step.sv
hw/rtl/mdb_obuf.sv
hw/rtl/morse_digit_beacon_core.sv
sim/morse_digit_beacon_core_test.sv
